>>> sv/vca_pkg.sv
// Shared types, codes and helpers for the voice channel allocator.
`timescale 1ns / 1ps
`default_nettype none

package vca_pkg;

  localparam int unsigned ChanW          = 4;
  localparam int unsigned CntW           = 5;
  localparam int unsigned ChanLimit      = 16;
  localparam int unsigned MaxChannelsDef = 16;
  localparam logic [CntW-1:0] ActiveReset = 5'd16;

  localparam logic REG_ACTIVE  = 1'b0;
  localparam logic REG_DISABLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_BUSY = 2'd1,
    MODE_RES  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_OFF  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_SAMPLE_END = 2'd1,
    EV_RELEASED   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    CMD_RESERVE     = 3'd0,
    CMD_RELEASE     = 3'd1,
    CMD_PLAY        = 3'd2,
    CMD_FINISHED    = 3'd3,
    CMD_RELEASE_ALL = 3'd4,
    CMD_SET_NOTIFY  = 3'd5,
    CMD_CLR_NOTIFY  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] idx;
    mode_e            mode;
    logic             ntf;
  } tbl_wr_t;

  typedef struct packed {
    logic            en;
    logic [CntW-1:0] live;
  } tbl_shrink_t;

  function automatic logic [CntW-1:0] live_count(input logic [CntW-1:0] a,
                                                 input logic [CntW-1:0] lim);
    logic [CntW-1:0] n;
    n = a;
    if (n == '0) n = 5'd1;
    if (n > lim) n = lim;
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/voice_channel_allocator.sv
// The final word loads in state S_FIN, entered from the last table step, or from accept
// when no step is needed (disabled, bad channel, zero loop count, unused command code).
// Steps: 1 for a single-channel command, 1 to live_count for reserve and play, live_count
// for release-all; a release-all step on a reserved, notified channel waits while a word waits.
// Throughput: one command at a time; the final load holds while a word waits.
// Reset: all channels free, notify marks clear, 16 active channels, sound enabled.
`timescale 1ns / 1ps
`default_nettype none

module voice_channel_allocator import vca_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // command[2:0], channel[6:3], loop_count[14:7]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // status[1:0], granted_channel[5:2], event_res[7:6]
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned LiveMax = (MAX_CHANNELS > ChanLimit) ? ChanLimit : MAX_CHANNELS;
  localparam logic [CntW-1:0] LiveMaxC = CntW'(LiveMax);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [ChanW-1:0] ch_q, ch_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [ChanW-1:0] idx_q, idx_d;
  logic             bf_q, bf_d;
  logic [ChanW-1:0] bi_q, bi_d;
  status_e          rst_q, rst_d;
  logic [ChanW-1:0] rch_q, rch_d;
  event_e           rev_q, rev_d;

  logic             mv_q, mv_d;
  status_e          mst_q, mst_d;
  logic [ChanW-1:0] mch_q, mch_d;
  event_e           mev_q, mev_d;
  logic             mlast_q, mlast_d;

  logic [CntW-1:0]  active_q;
  logic             dis_q;

  mode_e            rd_mode;
  logic             rd_ntf;
  tbl_wr_t          wr;
  tbl_shrink_t      shrink;

  cmd_e             in_cmd;
  logic [ChanW-1:0] in_ch;
  logic [7:0]       in_loops;
  logic [CntW-1:0]  in_n;
  logic             in_range;
  logic             out_free;
  logic             last_ent;
  logic             cfg_wr;

  assign in_cmd   = cmd_e'(s_axis_tdata[2:0]);
  assign in_ch    = s_axis_tdata[6:3];
  assign in_loops = s_axis_tdata[14:7];
  assign in_n     = live_count(active_q, LiveMaxC);
  assign in_range = {1'b0, in_ch} < in_n;
  assign out_free = !mv_q || m_axis_tready;
  assign last_ent = ({1'b0, idx_q} + 5'd1) == n_q;

  assign s_axis_tready = (state_q == S_IDLE);

  vca_table #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q),
    .rd_mode_o (rd_mode),
    .rd_ntf_o  (rd_ntf),
    .wr_i      (wr),
    .shrink_i  (shrink)
  );

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ch_d    = ch_q;
    n_d     = n_q;
    idx_d   = idx_q;
    bf_d    = bf_q;
    bi_d    = bi_q;
    rst_d   = rst_q;
    rch_d   = rch_q;
    rev_d   = rev_q;
    mv_d    = mv_q && !m_axis_tready;
    mst_d   = mst_q;
    mch_d   = mch_q;
    mev_d   = mev_q;
    mlast_d = mlast_q;
    wr      = '{en: 1'b0, idx: idx_q, mode: MODE_FREE, ntf: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = in_cmd;
          ch_d  = in_ch;
          n_d   = in_n;
          bf_d  = 1'b0;
          idx_d = '0;
          rev_d = EV_NONE;
          rch_d = '0;
          if (dis_q) begin
            rst_d   = ST_OFF;
            state_d = S_FIN;
          end else begin
            case (in_cmd)
              CMD_RESERVE, CMD_RELEASE_ALL: begin
                state_d = S_RUN;
              end
              CMD_PLAY: begin
                if (in_loops == '0) begin
                  rst_d   = ST_OK;
                  state_d = S_FIN;
                end else begin
                  state_d = S_RUN;
                end
              end
              CMD_RELEASE, CMD_FINISHED, CMD_SET_NOTIFY, CMD_CLR_NOTIFY: begin
                idx_d = in_ch;
                rch_d = in_ch;
                if (in_range) begin
                  state_d = S_RUN;
                end else begin
                  rst_d   = ST_BAD;
                  state_d = S_FIN;
                end
              end
              default: begin
                rst_d   = ST_BAD;
                rch_d   = in_ch;
                state_d = S_FIN;
              end
            endcase
          end
        end
      end

      S_RUN: begin
        case (cmd_q)
          CMD_RESERVE, CMD_PLAY: begin
            if (rd_mode == MODE_FREE) begin
              wr.en   = 1'b1;
              wr.idx  = idx_q;
              wr.mode = (cmd_q == CMD_RESERVE) ? MODE_RES : MODE_BUSY;
              wr.ntf  = (cmd_q == CMD_RESERVE) ? 1'b0 : rd_ntf;
              rst_d   = ST_OK;
              rch_d   = idx_q;
              state_d = S_FIN;
            end else if (last_ent) begin
              if ((cmd_q == CMD_RESERVE) && (bf_q || (rd_mode == MODE_BUSY))) begin
                wr.en   = 1'b1;
                wr.idx  = bf_q ? bi_q : idx_q;
                wr.mode = MODE_RES;
                wr.ntf  = 1'b0;
                rst_d   = ST_OK;
                rch_d   = bf_q ? bi_q : idx_q;
              end else begin
                rst_d   = ST_NONE;
                rch_d   = '0;
              end
              state_d = S_FIN;
            end else begin
              idx_d = idx_q + 4'd1;
              if ((rd_mode == MODE_BUSY) && !bf_q) begin
                bf_d = 1'b1;
                bi_d = idx_q;
              end
            end
          end

          CMD_RELEASE_ALL: begin
            if (!((rd_mode == MODE_RES) && rd_ntf && !out_free)) begin
              if (rd_mode == MODE_RES) begin
                wr.en   = 1'b1;
                wr.mode = MODE_FREE;
                wr.ntf  = 1'b0;
                if (rd_ntf) begin
                  mv_d    = 1'b1;
                  mst_d   = ST_OK;
                  mch_d   = idx_q;
                  mev_d   = EV_RELEASED;
                  mlast_d = 1'b0;
                end
              end
              if (last_ent) begin
                rst_d   = ST_OK;
                rch_d   = '0;
                state_d = S_FIN;
              end else begin
                idx_d = idx_q + 4'd1;
              end
            end
          end

          CMD_RELEASE: begin
            if (rd_mode != MODE_RES) begin
              rst_d = ST_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.mode = MODE_FREE;
              wr.ntf  = 1'b0;
              rst_d   = ST_OK;
            end
            state_d = S_FIN;
          end

          CMD_FINISHED: begin
            if (rd_mode == MODE_FREE) begin
              rst_d = ST_BAD;
            end else if (rd_mode == MODE_BUSY) begin
              wr.en   = 1'b1;
              wr.mode = MODE_FREE;
              wr.ntf  = rd_ntf;
              rst_d   = ST_OK;
            end else begin
              rst_d = ST_OK;
              rev_d = rd_ntf ? EV_SAMPLE_END : EV_NONE;
            end
            state_d = S_FIN;
          end

          CMD_SET_NOTIFY, CMD_CLR_NOTIFY: begin
            if ((rd_mode != MODE_RES) || (rd_ntf == (cmd_q == CMD_SET_NOTIFY))) begin
              rst_d = ST_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.mode = MODE_RES;
              wr.ntf  = (cmd_q == CMD_SET_NOTIFY);
              rst_d   = ST_OK;
            end
            state_d = S_FIN;
          end

          default: begin
            rst_d   = ST_BAD;
            state_d = S_FIN;
          end
        endcase
      end

      S_FIN: begin
        if (out_free) begin
          mv_d    = 1'b1;
          mst_d   = rst_q;
          mch_d   = rch_q;
          mev_d   = rev_q;
          mlast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_wr      = psel && penable && pwrite && pready;
  assign shrink.en   = cfg_wr && (paddr[2] == REG_ACTIVE);
  assign shrink.live = live_count(pwdata[CntW-1:0], LiveMaxC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mv_q     <= 1'b0;
      active_q <= ActiveReset;
      dis_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_ACTIVE) begin
          active_q <= pwdata[CntW-1:0];
        end else begin
          dis_q <= pwdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    ch_q    <= ch_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    bf_q    <= bf_d;
    bi_q    <= bi_d;
    rst_q   <= rst_d;
    rch_q   <= rch_d;
    rev_q   <= rev_d;
    mst_q   <= mst_d;
    mch_q   <= mch_d;
    mev_q   <= mev_d;
    mlast_q <= mlast_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {mev_q, mch_q, mst_q};
  assign m_axis_tlast  = mlast_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE) ? {27'd0, active_q} : {31'd0, dis_q};

endmodule

`default_nettype wire

>>> sv/vca_table.sv
// Channel table: mode and notify mark per channel, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none

module vca_table import vca_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ChanW-1:0] rd_idx_i,
  output mode_e                 rd_mode_o,
  output logic                  rd_ntf_o,
  input  wire tbl_wr_t          wr_i,
  input  wire tbl_shrink_t      shrink_i
);

  localparam int unsigned Depth = (MAX_CHANNELS > ChanLimit) ? ChanLimit : MAX_CHANNELS;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  mode_e mode_q [Depth];
  logic  ntf_q  [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        mode_q[i] <= MODE_FREE;
        ntf_q[i]  <= 1'b0;
      end
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (shrink_i.en && (CntW'(i) >= shrink_i.live)) begin
          mode_q[i] <= MODE_FREE;
          ntf_q[i]  <= 1'b0;
        end else if (wr_i.en && (wr_i.idx == ChanW'(i))) begin
          mode_q[i] <= wr_i.mode;
          ntf_q[i]  <= wr_i.ntf;
        end
      end
    end
  end

  assign rd_mode_o = mode_q[rd_idx_i[IdxW-1:0]];
  assign rd_ntf_o  = ntf_q[rd_idx_i[IdxW-1:0]];

endmodule

`default_nettype wire

>>> tb/sv/voice_channel_allocator_tb.sv
// Self-checking testbench for the voice channel allocator: command stream, event words, APB setup.
`timescale 1ns / 1ps

module voice_channel_allocator_tb;
  import vca_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    status_e    st;
    logic [3:0] chan;
    event_e     ev;
    logic       last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [7:0]  m_axis_tdata;
  wire         m_axis_tlast;
  wire  [31:0] prdata;
  wire         pready;

  voice_channel_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),        // command[2:0], channel[6:3], loop_count[14:7]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),  // status[1:0], granted_channel[5:2], event_res[7:6]
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mode_e       ch_mode [ChanLimit];
  bit          ch_notify [ChanLimit];
  logic [4:0]  live_reg;
  bit          mute_reg;
  logic [15:0] cmd_q[$];
  reply_t      reply_q[$];
  int          mismatches = 0;
  int          cmd_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  bit          cmd_hs = 1'b0;
  bit          m_hs = 1'b0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int live_chans();
    int n;
    n = live_reg;
    if (n == 0) n = 1;
    if (n > ChanLimit) n = ChanLimit;
    return n;
  endfunction

  function automatic int find_mode(input int n, input mode_e m);
    for (int i = 0; i < n; i++) begin
      if (ch_mode[i] == m) return i;
    end
    return -1;
  endfunction

  function automatic void add_reply(input status_e s, input logic [3:0] c, input event_e e,
                                    input logic l);
    reply_t r;
    r.st = s;
    r.chan = c;
    r.ev = e;
    r.last = l;
    reply_q.push_back(r);
  endfunction

  function automatic void allocate_cmd(input logic [15:0] w);
    logic [3:0] ch;
    logic [7:0] loops;
    int         n;
    int         f;
    bit         inr;
    ch = w[6:3];
    loops = w[14:7];
    n = live_chans();
    inr = ch < n;
    if (mute_reg) begin
      add_reply(ST_OFF, 4'd0, EV_NONE, 1'b1);
      return;
    end
    case (w[2:0])
      CMD_RESERVE: begin
        f = find_mode(n, MODE_FREE);
        if (f < 0) f = find_mode(n, MODE_BUSY);
        if (f < 0) begin
          add_reply(ST_NONE, 4'd0, EV_NONE, 1'b1);
        end else begin
          ch_mode[f] = MODE_RES;
          ch_notify[f] = 1'b0;
          add_reply(ST_OK, 4'(f), EV_NONE, 1'b1);
        end
      end
      CMD_RELEASE: begin
        if (!inr || ch_mode[ch] != MODE_RES) begin
          add_reply(ST_BAD, ch, EV_NONE, 1'b1);
        end else begin
          ch_mode[ch] = MODE_FREE;
          ch_notify[ch] = 1'b0;
          add_reply(ST_OK, ch, EV_NONE, 1'b1);
        end
      end
      CMD_PLAY: begin
        f = find_mode(n, MODE_FREE);
        if (loops == 8'd0) begin
          add_reply(ST_OK, 4'd0, EV_NONE, 1'b1);
        end else if (f < 0) begin
          add_reply(ST_NONE, 4'd0, EV_NONE, 1'b1);
        end else begin
          ch_mode[f] = MODE_BUSY;
          add_reply(ST_OK, 4'(f), EV_NONE, 1'b1);
        end
      end
      CMD_FINISHED: begin
        if (!inr || ch_mode[ch] == MODE_FREE) begin
          add_reply(ST_BAD, ch, EV_NONE, 1'b1);
        end else if (ch_mode[ch] == MODE_BUSY) begin
          ch_mode[ch] = MODE_FREE;
          add_reply(ST_OK, ch, EV_NONE, 1'b1);
        end else begin
          add_reply(ST_OK, ch, ch_notify[ch] ? EV_SAMPLE_END : EV_NONE, 1'b1);
        end
      end
      CMD_RELEASE_ALL: begin
        for (int i = 0; i < n; i++) begin
          if (ch_mode[i] == MODE_RES) begin
            ch_mode[i] = MODE_FREE;
            if (ch_notify[i]) begin
              ch_notify[i] = 1'b0;
              add_reply(ST_OK, 4'(i), EV_RELEASED, 1'b0);
            end
          end
        end
        add_reply(ST_OK, 4'd0, EV_NONE, 1'b1);
      end
      CMD_SET_NOTIFY: begin
        if (!inr || ch_mode[ch] != MODE_RES || ch_notify[ch]) begin
          add_reply(ST_BAD, ch, EV_NONE, 1'b1);
        end else begin
          ch_notify[ch] = 1'b1;
          add_reply(ST_OK, ch, EV_NONE, 1'b1);
        end
      end
      CMD_CLR_NOTIFY: begin
        if (!inr || ch_mode[ch] != MODE_RES || !ch_notify[ch]) begin
          add_reply(ST_BAD, ch, EV_NONE, 1'b1);
        end else begin
          ch_notify[ch] = 1'b0;
          add_reply(ST_OK, ch, EV_NONE, 1'b1);
        end
      end
      default: begin
        add_reply(ST_BAD, ch, EV_NONE, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [15:0] cmd_word(input logic [2:0] c, input logic [3:0] ch,
                                           input logic [7:0] lp);
    return {1'b0, lp, ch, c};
  endfunction

  function automatic logic [15:0] rand_cmd(input int n);
    logic [2:0] c;
    logic [3:0] ch;
    logic [7:0] lp;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 20) c = CMD_RESERVE;
    else if (r < 32) c = CMD_RELEASE;
    else if (r < 48) c = CMD_PLAY;
    else if (r < 63) c = CMD_FINISHED;
    else if (r < 68) c = CMD_RELEASE_ALL;
    else if (r < 81) c = CMD_SET_NOTIFY;
    else if (r < 94) c = CMD_CLR_NOTIFY;
    else c = 3'($urandom_range(0, 7));
    ch = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
    lp = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
    return cmd_word(c, ch, lp);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_random(input int count, input int n);
    for (int i = 0; i < count; i++) cmd_q.push_back(rand_cmd(n));
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || s_valid || reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] want;
    wait_idle();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ACTIVE) begin
      live_reg = val[4:0];
      for (int i = live_chans(); i < ChanLimit; i++) begin
        ch_mode[i] = MODE_FREE;
        ch_notify[i] = 1'b0;
      end
      want = {27'd0, val[4:0]};
    end else begin
      mute_reg = val[0];
      want = {31'd0, val[0]};
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %0h, got %0h", $time, idx, want, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // command side: hold each word until taken, then insert a gap
  always @(negedge clk_i) begin : cmd_driver
    logic        v_nxt;
    logic [15:0] d_nxt;
    v_nxt = s_valid;
    d_nxt = s_data;
    if (rst_ni) begin
      if (cmd_hs) begin
        cmd_hs = 1'b0;
        v_nxt = 1'b0;
        cmd_gap = pick_gap(calm_in);
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
      end
      if (!v_nxt) begin
        if (cmd_gap > 0) cmd_gap--;
        else if (cmd_q.size() != 0) begin
          d_nxt = cmd_q.pop_front();
          v_nxt = 1'b1;
        end
      end
    end
    s_valid <= v_nxt;
    s_data <= d_nxt;
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (m_hs) begin
        m_hs = 1'b0;
        out_gap = pick_gap(calm_out);
        if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : word_monitor
    reply_t want;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        allocate_cmd(s_data);
        cmd_hs = 1'b1;
      end
      if (m_axis_tvalid && m_ready) begin
        m_hs = 1'b1;
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected word status=%0d chan=%0d event=%0d last=%0b", $time,
                   m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[7:6], m_axis_tlast);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata[1:0] !== want.st || m_axis_tdata[5:2] !== want.chan ||
              m_axis_tdata[7:6] !== want.ev || m_axis_tlast !== want.last) begin
            $display("%0t: expected status=%0d chan=%0d event=%0d last=%0b, got status=%0d chan=%0d event=%0d last=%0b",
                     $time, want.st, want.chan, want.ev, want.last, m_axis_tdata[1:0],
                     m_axis_tdata[5:2], m_axis_tdata[7:6], m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int a;
    for (int i = 0; i < ChanLimit; i++) begin
      ch_mode[i] = MODE_FREE;
      ch_notify[i] = 1'b0;
    end
    live_reg = ActiveReset;
    mute_reg = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd15, 8'd255));
    cmd_q.push_back(cmd_word(CMD_SET_NOTIFY, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_SET_NOTIFY, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_CLR_NOTIFY, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd15, 8'd255));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd0, 8'd1));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd2, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd2, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RELEASE, 4'd3, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RELEASE, 4'd15, 8'd0));
    cmd_q.push_back(cmd_word(CMD_SET_NOTIFY, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_CLR_NOTIFY, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_SET_NOTIFY, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_UNUSED, 4'd9, 8'd170));
    cmd_q.push_back(cmd_word(CMD_RELEASE_ALL, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RELEASE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_CLR_NOTIFY, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd3, 8'd0));
    push_random(50, 16);

    // two channels: clear them, fill with sounds, then steal
    write_reg(REG_ACTIVE, 32'd2);
    cmd_q.push_back(cmd_word(CMD_RELEASE_ALL, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_FINISHED, 4'd1, 8'd0));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd0, 8'd1));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd0, 8'd2));
    cmd_q.push_back(cmd_word(CMD_PLAY, 4'd0, 8'd3));
    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RESERVE, 4'd0, 8'd0));
    cmd_q.push_back(cmd_word(CMD_RELEASE, 4'd5, 8'd0));
    push_random(60, 2);

    write_reg(REG_ACTIVE, 32'd1);
    push_random(30, 1);
    write_reg(REG_ACTIVE, 32'd0);
    push_random(20, 1);

    // block the result side while commands keep coming
    write_reg(REG_ACTIVE, 32'd5);
    hold_req = 1'b1;
    push_random(80, 5);

    write_reg(REG_DISABLE, 32'd1);
    write_reg(REG_ACTIVE, 32'd20);
    push_random(30, 16);
    write_reg(REG_DISABLE, 32'd0);
    push_random(60, 16);

    write_reg(REG_ACTIVE, 32'd3);
    push_random(60, 3);

    for (int k = 0; k < 4; k++) begin
      a = $urandom_range(1, 16);
      write_reg(REG_ACTIVE, 32'(a));
      push_random(12, a);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
